[hdl/sbf_pkg.sv]
`timescale 1ns / 1ps

package sbf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int WIN_W    = 4;
    localparam int GAIN_W   = 10;
    localparam int DELAY_W  = 12;
    localparam int FRAC_W   = 10;

    localparam int DEF_RING_DEPTH = 4096;
    localparam int DEF_MAX_WINDOW = 8;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [1:0] REG_WINDOW = 2'd0;
    localparam logic [1:0] REG_GAIN   = 2'd1;
    localparam logic [1:0] REG_DELAY  = 2'd2;

    localparam logic [WIN_W-1:0]   WINDOW_RST = 4'd4;
    localparam logic [GAIN_W-1:0]  GAIN_RST   = 10'd125;
    localparam logic [DELAY_W-1:0] DELAY_RST  = 12'd3950;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_in;
        logic signed [SAMPLE_W-1:0] right_in;
    } sbf_sample_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
    } sbf_result_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
    } sbf_pair_t;

    typedef struct packed {
        logic [WIN_W-1:0]   window_length;
        logic [GAIN_W-1:0]  gain;
        logic [DELAY_W-1:0] delay_samples;
    } sbf_cfg_t;

endpackage

[hdl/sbf_front.sv]
`timescale 1ns / 1ps

module sbf_front
    import sbf_pkg::*;
#(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    output logic        sample_stall,
    input  sbf_sample_t sample,
    input  sbf_cfg_t    cfg,
    output logic        push,
    output sbf_pair_t   push_data,
    input  logic        q_full
);

    // window_length is 4 bits, so at most 15 samples are ever summed
    localparam int NSUM   = (MAX_WINDOW < 16) ? MAX_WINDOW : 15;
    localparam int SUM_W  = SAMPLE_W + $clog2(NSUM);
    localparam int PROD_W = SUM_W + GAIN_W + 1;

    typedef logic signed [SAMPLE_W-1:0] hist_t [MAX_WINDOW];

    hist_t lhist_reg;
    hist_t rhist_reg;

    logic                     s1_valid_reg;
    logic                     s1_valid_next;
    logic signed [SUM_W-1:0]  lsum_reg;
    logic signed [SUM_W-1:0]  rsum_reg;
    logic                     s2_valid_reg;
    logic                     s2_valid_next;
    logic signed [PROD_W-1:0] lprod_reg;
    logic signed [PROD_W-1:0] rprod_reg;

    logic                     s2_ready;
    logic                     s1_fwd;
    logic                     s1_ready;
    logic                     accept;
    logic signed [GAIN_W:0]   gain_s;

    function automatic logic signed [SUM_W-1:0] win_sum(
        input logic signed [SAMPLE_W-1:0] x,
        input hist_t                      h,
        input logic [WIN_W-1:0]           n
    );
        logic signed [SUM_W-1:0] s;
        s = SUM_W'(x);
        for (int i = 0; i < NSUM - 1; i++)
        begin
            if (i + 2 <= int'(n))
            begin
                s = s + SUM_W'(h[i]);
            end
        end
        if (n == '0)
        begin
            s = '0;
        end
        return s;
    endfunction

    // product / 1024 toward zero, low 16 bits kept
    function automatic logic signed [SAMPLE_W-1:0] scale(
        input logic signed [PROD_W-1:0] p
    );
        logic signed [PROD_W-1:0] biased;
        biased = p + (p[PROD_W-1] ? PROD_W'((1 << FRAC_W) - 1) : PROD_W'(0));
        return biased[FRAC_W+SAMPLE_W-1:FRAC_W];
    endfunction

    assign push          = s2_valid_reg && !q_full;
    assign s2_ready      = !s2_valid_reg || !q_full;
    assign s1_fwd        = s1_valid_reg && s2_ready;
    assign s1_ready      = !s1_valid_reg || s2_ready;
    assign accept        = sample_valid && s1_ready;
    assign sample_stall  = !s1_ready;
    assign s1_valid_next = accept || (s1_valid_reg && !s2_ready);
    assign s2_valid_next = s1_fwd || (s2_valid_reg && q_full);
    assign gain_s        = {1'b0, cfg.gain};

    assign push_data.left  = scale(lprod_reg);
    assign push_data.right = scale(rprod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_WINDOW; i++)
            begin
                lhist_reg[i] <= '0;
                rhist_reg[i] <= '0;
            end
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            if (accept)
            begin
                lhist_reg[0] <= sample.left_in;
                rhist_reg[0] <= sample.right_in;
                for (int i = 1; i < MAX_WINDOW; i++)
                begin
                    lhist_reg[i] <= lhist_reg[i-1];
                    rhist_reg[i] <= rhist_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lsum_reg <= win_sum(sample.left_in, lhist_reg, cfg.window_length);
            rsum_reg <= win_sum(sample.right_in, rhist_reg, cfg.window_length);
        end
        if (s1_fwd)
        begin
            lprod_reg <= PROD_W'(lsum_reg) * PROD_W'(gain_s);
            rprod_reg <= PROD_W'(rsum_reg) * PROD_W'(gain_s);
        end
    end

endmodule

[hdl/sbf_queue.sv]
`timescale 1ns / 1ps

module sbf_queue
    import sbf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  sbf_pair_t push_data,
    output logic      full,
    input  logic      pop,
    output logic      q_valid,
    output sbf_pair_t q_data
);

    sbf_pair_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;
    logic [QPTR_W:0]     count_next;

    assign full    = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hdl/sbf_back.sv]
`timescale 1ns / 1ps

module sbf_back
    import sbf_pkg::*;
#(
    parameter int RING_DEPTH = DEF_RING_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  sbf_pair_t          q_data,
    output logic               pop,
    input  logic [DELAY_W-1:0] delay_samples,
    output logic               result_valid,
    input  logic               result_stall,
    output sbf_result_t        result
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int DW = (AW > DELAY_W) ? AW : DELAY_W;

    sbf_pair_t     ring [RING_DEPTH];

    logic [AW-1:0] wp_reg;
    logic [AW:0]   fill_reg;
    logic          res_valid_reg;
    logic          res_valid_next;
    sbf_pair_t     rdata_reg;
    sbf_pair_t     wdata_reg;
    logic          bypass_reg;
    logic          blank_reg;

    logic [DW-1:0] delay_ext;
    logic [AW-1:0] rd_dist;
    logic [AW-1:0] rd_addr;
    sbf_pair_t     sel;

    assign delay_ext      = DW'(delay_samples);
    assign rd_dist        = delay_ext[AW-1:0];
    assign rd_addr        = wp_reg - rd_dist;
    assign pop            = q_valid && (!res_valid_reg || !result_stall);
    assign res_valid_next = pop || (res_valid_reg && result_stall);
    assign result_valid   = res_valid_reg;

    // entries not yet written since reset read as zero
    always_comb
    begin
        if (blank_reg)
        begin
            sel = '0;
        end
        else if (bypass_reg)
        begin
            sel = wdata_reg;
        end
        else
        begin
            sel = rdata_reg;
        end
    end

    assign result.left_out  = sel.left;
    assign result.right_out = sel.right;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            fill_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (pop)
            begin
                wp_reg <= wp_reg + 1'b1;
                if (fill_reg != (AW+1)'(RING_DEPTH))
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ring[wp_reg] <= q_data;
            rdata_reg    <= ring[rd_addr];
            wdata_reg    <= q_data;
            bypass_reg   <= (rd_dist == '0);
            blank_reg    <= ((AW+1)'(rd_dist) > fill_reg);
        end
    end

endmodule

[hdl/stereo_boxcar_filter_delay.sv]
`timescale 1ns / 1ps

// Stereo boxcar filter with delay line. Each item is one left/right pair of
// signed 16-bit samples and yields exactly one result pair. Sustained rate is
// one item per clock while result_stall is low. From sample accept to result
// valid it passes window sum, gain product, queue and ring read registers.
// The front end stalls only when the 4-entry queue fills; the back end stalls
// only on result_stall. Ring storage is one RING_DEPTH x 32 memory with one
// write and one read port per cycle; RING_DEPTH must be a power of two. No
// clearing pass after reset: a fill count makes unwritten ring entries read
// as zero. Registers: 0x0 window_length, 0x4 gain, 0x8 delay_samples; write
// only while the block is idle.

module stereo_boxcar_filter_delay
    import sbf_pkg::*;
#(
    parameter int RING_DEPTH = DEF_RING_DEPTH,
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  sbf_sample_t       sample,
    output logic              result_valid,
    input  logic              result_stall,
    output sbf_result_t       result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    sbf_cfg_t  cfg_reg;
    logic      push;
    sbf_pair_t push_data;
    logic      q_full;
    logic      pop;
    logic      q_valid;
    sbf_pair_t q_data;
    logic      wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_length <= WINDOW_RST;
            cfg_reg.gain          <= GAIN_RST;
            cfg_reg.delay_samples <= DELAY_RST;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_WINDOW: cfg_reg.window_length <= pwdata[WIN_W-1:0];
                REG_GAIN:   cfg_reg.gain          <= pwdata[GAIN_W-1:0];
                REG_DELAY:  cfg_reg.delay_samples <= pwdata[DELAY_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_WINDOW: prdata = DATA_W'(cfg_reg.window_length);
            REG_GAIN:   prdata = DATA_W'(cfg_reg.gain);
            REG_DELAY:  prdata = DATA_W'(cfg_reg.delay_samples);
            default:    prdata = '0;
        endcase
    end

    sbf_front #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .cfg          (cfg_reg),
        .push         (push),
        .push_data    (push_data),
        .q_full       (q_full)
    );

    sbf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    sbf_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_data        (q_data),
        .pop           (pop),
        .delay_samples (cfg_reg.delay_samples),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result        (result)
    );

endmodule

[tb/stereo_boxcar_filter_delay_tb.sv]
`timescale 1ns / 1ps

module stereo_boxcar_filter_delay_tb;

    import sbf_pkg::*;

    localparam int LEFT        = 0;
    localparam int RIGHT       = 1;
    localparam int STUCK_LIMIT = 5000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              sample_valid = 1'b0;
    logic              sample_stall;
    sbf_sample_t       sample = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    sbf_result_t       result;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    stereo_boxcar_filter_delay i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // shadow of the filter state
    logic [WIN_W-1:0]           win_cfg = WINDOW_RST;
    logic [GAIN_W-1:0]          gain_cfg = GAIN_RST;
    logic [DELAY_W-1:0]         delay_cfg = DELAY_RST;
    logic signed [SAMPLE_W-1:0] history [2][DEF_MAX_WINDOW];
    logic [SAMPLE_W-1:0]        ring [2][DEF_RING_DEPTH];
    logic [DELAY_W-1:0]         wr_ptr = '0;

    sbf_sample_t samples_to_send [$];
    sbf_result_t delayed_pairs [$];

    bit sample_taken = 1'b0;
    bit idle_en = 1'b1;
    int send_gap = 0;
    int stall_gap = 0;
    int stuck_cycles = 0;
    int fails = 0;

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic [SAMPLE_W-1:0] boxcar_scale(int ch, logic signed [SAMPLE_W-1:0] x);
        int     n;
        int     acc;
        longint prod;
        longint quo;
        n = (win_cfg > DEF_MAX_WINDOW) ? DEF_MAX_WINDOW : int'(win_cfg);
        acc = 0;
        if (n > 0)
        begin
            acc = x;
            for (int i = 0; i < n - 1; i++)
                acc += history[ch][i];
        end
        for (int i = DEF_MAX_WINDOW - 1; i > 0; i--)
            history[ch][i] = history[ch][i-1];
        history[ch][0] = x;
        prod = longint'(acc) * longint'(gain_cfg);
        quo = prod / 1024;
        return quo[SAMPLE_W-1:0];
    endfunction

    function automatic sbf_result_t filter_pair(sbf_sample_t s);
        sbf_result_t        r;
        logic [DELAY_W-1:0] rd;
        ring[LEFT][wr_ptr] = boxcar_scale(LEFT, s.left_in);
        ring[RIGHT][wr_ptr] = boxcar_scale(RIGHT, s.right_in);
        rd = wr_ptr - delay_cfg;
        r.left_out = ring[LEFT][rd];
        r.right_out = ring[RIGHT][rd];
        wr_ptr = wr_ptr + 1'b1;
        return r;
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_level();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'(int'($urandom_range(0, 15)) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic apb_write(logic [1:0] idx, logic [DATA_W-1:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_WINDOW: win_cfg = val[WIN_W-1:0];
            REG_GAIN:   gain_cfg = val[GAIN_W-1:0];
            REG_DELAY:  delay_cfg = val[DELAY_W-1:0];
            default: ;
        endcase
    endtask

    // upper bits of pwdata are random; only the field is kept
    task automatic set_config(int win, int gain, int delay);
        logic [DATA_W-1:0] junk;
        junk = $urandom;
        apb_write(REG_WINDOW, {junk[31:WIN_W], 4'(win)});
        junk = $urandom;
        apb_write(REG_GAIN, {junk[31:GAIN_W], 10'(gain)});
        junk = $urandom;
        apb_write(REG_DELAY, {junk[31:DELAY_W], 12'(delay)});
    endtask

    task automatic push_pair(int l, int r);
        sbf_sample_t s;
        s.left_in = 16'(l);
        s.right_in = 16'(r);
        samples_to_send.push_back(s);
    endtask

    task automatic push_random(int n);
        sbf_sample_t s;
        int          run;
        while (n > 0)
        begin
            // runs of steady levels now and then so window sums get large
            run = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 9) : 1;
            s.left_in = rand_level();
            s.right_in = rand_level();
            for (int i = 0; i < run && n > 0; i++)
            begin
                samples_to_send.push_back(s);
                n--;
            end
        end
    endtask

    task automatic drain();
        while (samples_to_send.size() != 0 || sample_valid || delayed_pairs.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic random_config();
        int win;
        int gain;
        int delay;
        win = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
        case ($urandom_range(0, 5))
            0: gain = 0;
            1: gain = 1023;
            default: gain = $urandom_range(0, 1023);
        endcase
        case ($urandom_range(0, 5))
            0: delay = 0;
            1: delay = 4095;
            2: delay = $urandom_range(0, 4095);
            default: delay = $urandom_range(0, 40);
        endcase
        set_config(win, gain, delay);
    endtask

    initial
    begin
        for (int c = 0; c < 2; c++)
        begin
            for (int i = 0; i < DEF_MAX_WINDOW; i++)
                history[c][i] = '0;
            for (int i = 0; i < DEF_RING_DEPTH; i++)
                ring[c][i] = '0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        push_random(20);
        drain();

        // full-scale window, quotient wraps
        set_config(8, 1023, 0);
        for (int i = 0; i < 8; i++)
            push_pair(32767, -32768);
        push_pair(0, -1);
        push_pair(-1, 0);
        push_pair(16'h5555, 16'hAAAA);
        push_pair(16'hAAAA, 16'h5555);
        drain();

        // empty window
        set_config(0, 512, 1);
        push_pair(32767, -32768);
        push_pair(-32768, 32767);
        push_pair(100, -100);
        push_pair(-1, 1);
        drain();

        // window beyond the history length saturates
        set_config(15, 1023, 2);
        for (int i = 0; i < 6; i++)
            push_pair(-32768, 32767);
        drain();

        set_config(1, 0, 4095);
        push_random(60);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            random_config();
            if (ph == 7)
                idle_en = 1'b0;
            push_random(75);
            drain();
        end

        if (fails == 0)
            $display("stereo_boxcar_filter_delay: match");
        else
            $display("stereo_boxcar_filter_delay: mismatch");
        $finish;
    end

    always @(negedge clk)
    begin : drive_samples
        logic        nxt_valid;
        sbf_sample_t nxt;
        nxt_valid = sample_valid;
        nxt = sample;
        if (rst_n && (!sample_valid || sample_taken))
        begin
            nxt_valid = 1'b0;
            if (send_gap > 0)
                send_gap--;
            else if (samples_to_send.size() != 0)
            begin
                nxt = samples_to_send.pop_front();
                nxt_valid = 1'b1;
                if (idle_en && $urandom_range(0, 7) == 0)
                    send_gap = $urandom_range(1, 7);
            end
        end
        sample_valid <= nxt_valid;
        sample <= nxt;
    end

    always @(negedge clk)
    begin : drive_stall
        logic nxt_stall;
        nxt_stall = 1'b0;
        if (stall_gap > 0)
        begin
            nxt_stall = 1'b1;
            stall_gap--;
        end
        else if (idle_en && $urandom_range(0, 7) == 0)
        begin
            nxt_stall = 1'b1;
            stall_gap = $urandom_range(1, 7) - 1;
        end
        result_stall <= nxt_stall;
    end

    always @(posedge clk)
    begin : check_results
        sbf_result_t want;
        bit          moved;
        sample_taken = rst_n && sample_valid && !sample_stall;
        moved = sample_taken;
        if (sample_taken)
            delayed_pairs.push_back(filter_pair(sample));
        if (rst_n && result_valid && !result_stall)
        begin
            moved = 1'b1;
            if (delayed_pairs.size() == 0)
            begin
                $error("unexpected item left_out %0d right_out %0d",
                       result.left_out, result.right_out);
                fails++;
            end
            else
            begin
                want = delayed_pairs.pop_front();
                if (result.left_out !== want.left_out)
                begin
                    $error("left_out expected %0d actual %0d", want.left_out, result.left_out);
                    fails++;
                end
                if (result.right_out !== want.right_out)
                begin
                    $error("right_out expected %0d actual %0d",
                           want.right_out, result.right_out);
                    fails++;
                end
            end
        end
        if (moved || !rst_n)
            stuck_cycles = 0;
        else
        begin
            stuck_cycles++;
            if (stuck_cycles == STUCK_LIMIT)
            begin
                $display("stereo_boxcar_filter_delay: mismatch");
                $finish;
            end
        end
    end

endmodule
